// ===== sv/msq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types and constants for the melody note sequencer: the input and
// result words, action codes, configuration indexes and register defaults.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int ADDR_IN_W = 9;
  localparam int FREQ_W    = 12;
  localparam int DUR_W     = 12;
  localparam int LEN_W     = 10;
  localparam int TICK_W    = 16;
  localparam int LOOP_W    = 8;
  localparam int NOTE_W    = FREQ_W + DUR_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Actions carried in the input word
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PAUSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_REPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_FLOOR  = 2'd2;

  localparam logic [TICK_W-1:0] LOOP_PAUSE_RST = 16'd1000;
  localparam logic [LOOP_W-1:0] LOOP_REPS_RST  = 8'd1;
  localparam logic [DUR_W-1:0]  GAP_FLOOR_RST  = 12'd20;

  // duration / 10 as (duration * 6554) >> 16, exact for 12-bit durations
  localparam logic [12:0] GAP_RECIP = 13'd6554;
  localparam int          GAP_SHIFT = 16;

  typedef struct packed {
    logic [1:0]           action;
    logic [ADDR_IN_W-1:0] note_address;
    logic [FREQ_W-1:0]    note_frequency;
    logic [DUR_W-1:0]     note_duration;
    logic [ADDR_IN_W-1:0] melody_start;
    logic [LEN_W-1:0]     melody_length;
  } msq_in_t;

  typedef struct packed {
    logic              tone_on;
    logic [FREQ_W-1:0] tone_frequency;
    logic              playing;
    logic              finished;
  } msq_out_t;

endpackage

// ===== sv/msq_note_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_note_mem
// Note memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msq_note_mem
  import msq_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [NOTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [NOTE_W-1:0] rdata
);

  logic [NOTE_W-1:0] mem [DEPTH];
  logic [NOTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/msq_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_out_queue
// Two-entry result queue; decouples the sequencer from output back-pressure.
// ----------------------------------------------------------------------------
module msq_out_queue
  import msq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  msq_out_t push_data,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output msq_out_t out_data
);

  msq_out_t   entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign room      = (cnt_r != 2'd2);
  assign out_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== sv/melody_note_sequencer.sv =====
`timescale 1ns / 1ps
// Path: a result word passes the input register and the result queue; a word
// that loads a note also waits for the registered read of the note memory.
// Throughput: one word per cycle while the result queue has room; a word that
// loads a note holds off the next until the registered note memory read returns.
// Reset: control state clears and the registers return to their defaults;
// the note memory keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
// melody_note_sequencer
// Plays melodies of frequency/duration pairs from a note memory, one tick per
// millisecond, with note gaps, a loop pause and a finished pulse.
// ----------------------------------------------------------------------------
module melody_note_sequencer
  import msq_pkg::*;
#(
  parameter int NOTE_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msq_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msq_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(NOTE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NOTE_DEPTH - 1);
  // address reduction by multiply with a reciprocal, exact for 9-bit inputs
  localparam int MOD_SH = 18;
  localparam logic [14:0] MOD_MUL = 15'(((1 << MOD_SH) + NOTE_DEPTH - 1) / NOTE_DEPTH);
  localparam logic [12:0] DEPTH_C = 13'(NOTE_DEPTH);

  typedef enum logic [1:0] {
    PH_TONE  = 2'd0,
    PH_GAP   = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_IN_W-1:0] x);
    logic [23:0] prod;
    logic [5:0]  quot;
    logic [18:0] back;
    logic [18:0] rem;
    prod = 24'(x) * 24'(MOD_MUL);
    quot = prod[23:MOD_SH];
    back = 19'(quot) * 19'(DEPTH_C);
    rem  = 19'(x) - back;
    return rem[AW-1:0];
  endfunction

  // Configuration
  logic [TICK_W-1:0] loop_pause_r;
  logic [LOOP_W-1:0] loop_reps_r;
  logic [DUR_W-1:0]  gap_floor_r;

  // Input register
  logic    in_vld_r;
  msq_in_t in_r;

  // Sequencer state
  logic              load_pend_r, load_pend_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     start_addr_r, start_addr_nxt;
  logic [LEN_W-1:0]  note_count_r, note_count_nxt;
  logic [LEN_W-1:0]  note_pos_r, note_pos_nxt;
  logic [DUR_W-1:0]  cur_dur_r, cur_dur_nxt;
  logic [FREQ_W-1:0] cur_freq_r, cur_freq_nxt;
  logic [DUR_W-1:0]  gap_len_r, gap_len_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  phase_t            phase_r, phase_nxt;
  logic              active_r, active_nxt;
  logic [LOOP_W-1:0] loops_r, loops_nxt;

  logic consume;
  logic q_room;
  logic q_push;
  msq_out_t q_data;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [NOTE_W-1:0] mem_rdata;

  logic [FREQ_W-1:0] ld_freq;
  logic [DUR_W-1:0]  ld_dur;
  logic [24:0]       ld_prod;
  logic [DUR_W-1:0]  ld_tenth;
  logic [DUR_W-1:0]  ld_gap;

  logic [TICK_W-1:0] el_inc;
  logic [LOOP_W:0]   loops_inc;
  logic [LEN_W-1:0]  pos_inc;
  logic [AW-1:0]     ptr_inc;
  logic [AW-1:0]     start_wrapped;
  logic              done;

  assign consume  = in_vld_r && !load_pend_r && q_room;
  assign in_ready = !in_vld_r || consume;

  // Gap of a freshly read note
  always_comb begin
    ld_freq  = mem_rdata[NOTE_W-1:DUR_W];
    ld_dur   = mem_rdata[DUR_W-1:0];
    ld_prod  = 25'(ld_dur) * 25'(GAP_RECIP);
    ld_tenth = DUR_W'(ld_prod[24:GAP_SHIFT]);
    ld_gap   = (ld_tenth < gap_floor_r) ? gap_floor_r : ld_tenth;
    if (ld_gap >= ld_dur || ld_freq == '0) begin
      ld_gap = '0;
    end
  end

  assign el_inc        = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign loops_inc     = {1'b0, loops_r} + 1'b1;
  assign pos_inc       = note_pos_r + 1'b1;
  assign ptr_inc       = (rd_ptr_r == LAST_ADDR) ? '0 : rd_ptr_r + 1'b1;
  assign start_wrapped = wrap_addr(in_r.melody_start);
  assign mem_waddr     = wrap_addr(in_r.note_address);
  assign mem_raddr     = rd_ptr_nxt;

  always_comb begin
    load_pend_nxt  = 1'b0;
    rd_ptr_nxt     = rd_ptr_r;
    start_addr_nxt = start_addr_r;
    note_count_nxt = note_count_r;
    note_pos_nxt   = note_pos_r;
    cur_dur_nxt    = cur_dur_r;
    cur_freq_nxt   = cur_freq_r;
    gap_len_nxt    = gap_len_r;
    elapsed_nxt    = elapsed_r;
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    loops_nxt      = loops_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    done           = 1'b0;
    q_push         = 1'b0;
    q_data         = '0;

    if (load_pend_r) begin
      // note word has arrived: latch it and report
      cur_freq_nxt = ld_freq;
      cur_dur_nxt  = ld_dur;
      gap_len_nxt  = ld_gap;
      q_push       = 1'b1;
    end else if (consume) begin
      case (in_r.action)
        ACT_TICK: begin
          if (active_r) begin
            elapsed_nxt = el_inc;
            case (phase_r)
              PH_PAUSE: begin
                if (el_inc >= loop_pause_r) begin
                  loops_nxt = loops_inc[LOOP_W-1:0];
                  if (loops_inc >= {1'b0, loop_reps_r}) begin
                    active_nxt = 1'b0;
                    done       = 1'b1;
                  end else begin
                    note_pos_nxt  = '0;
                    rd_ptr_nxt    = start_addr_r;
                    phase_nxt     = PH_TONE;
                    elapsed_nxt   = '0;
                    load_pend_nxt = 1'b1;
                  end
                end
              end
              PH_GAP: begin
                if (el_inc >= TICK_W'(gap_len_r)) begin
                  note_pos_nxt = pos_inc;
                  elapsed_nxt  = '0;
                  if (pos_inc >= note_count_r) begin
                    phase_nxt = PH_PAUSE;
                  end else begin
                    rd_ptr_nxt    = ptr_inc;
                    phase_nxt     = PH_TONE;
                    load_pend_nxt = 1'b1;
                  end
                end
              end
              default: begin
                if (el_inc >= TICK_W'(cur_dur_r - gap_len_r)) begin
                  elapsed_nxt = '0;
                  if (gap_len_r != '0) begin
                    phase_nxt = PH_GAP;
                  end else begin
                    note_pos_nxt = pos_inc;
                    if (pos_inc >= note_count_r) begin
                      phase_nxt = PH_PAUSE;
                    end else begin
                      rd_ptr_nxt    = ptr_inc;
                      phase_nxt     = PH_TONE;
                      load_pend_nxt = 1'b1;
                    end
                  end
                end
              end
            endcase
          end
        end
        ACT_START: begin
          if (in_r.melody_length != '0) begin
            start_addr_nxt = start_wrapped;
            rd_ptr_nxt     = start_wrapped;
            note_count_nxt = in_r.melody_length;
            note_pos_nxt   = '0;
            loops_nxt      = '0;
            active_nxt     = 1'b1;
            phase_nxt      = PH_TONE;
            elapsed_nxt    = '0;
            load_pend_nxt  = 1'b1;
          end
        end
        ACT_STOP: begin
          active_nxt = 1'b0;
        end
        default: begin
          mem_we = 1'b1;
        end
      endcase
      mem_re = load_pend_nxt;
      q_push = !load_pend_nxt;
    end

    q_data.tone_on        = active_nxt && (phase_nxt == PH_TONE) && (cur_freq_nxt != '0);
    q_data.tone_frequency = q_data.tone_on ? cur_freq_nxt : '0;
    q_data.playing        = active_nxt;
    q_data.finished       = done;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      load_pend_r  <= 1'b0;
      rd_ptr_r     <= '0;
      start_addr_r <= '0;
      note_count_r <= '0;
      note_pos_r   <= '0;
      cur_dur_r    <= '0;
      cur_freq_r   <= '0;
      gap_len_r    <= '0;
      elapsed_r    <= '0;
      phase_r      <= PH_TONE;
      active_r     <= 1'b0;
      loops_r      <= '0;
      loop_pause_r <= LOOP_PAUSE_RST;
      loop_reps_r  <= LOOP_REPS_RST;
      gap_floor_r  <= GAP_FLOOR_RST;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      load_pend_r  <= load_pend_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      start_addr_r <= start_addr_nxt;
      note_count_r <= note_count_nxt;
      note_pos_r   <= note_pos_nxt;
      cur_dur_r    <= cur_dur_nxt;
      cur_freq_r   <= cur_freq_nxt;
      gap_len_r    <= gap_len_nxt;
      elapsed_r    <= elapsed_nxt;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      loops_r      <= loops_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOOP_PAUSE: loop_pause_r <= cfg_wdata;
          CFG_LOOP_REPS:  loop_reps_r  <= cfg_wdata[LOOP_W-1:0];
          CFG_GAP_FLOOR:  gap_floor_r  <= cfg_wdata[DUR_W-1:0];
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end
    end
  end

  msq_note_mem #(
    .DEPTH (NOTE_DEPTH),
    .AW    (AW)
  ) u_note_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_r.note_frequency, in_r.note_duration}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  msq_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for melody_note_sequencer. Words go in over a
// valid/ready channel and the expected status of each one is predicted from a
// behavioural copy of the player (note store, phases, loop count, registers).
// The bench then compares every result word field by field, in order.
// Directed tests cover wrap, restart, stop and the loop and register
// extremes. A random part follows with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import msq_pkg::*;

  localparam int NOTE_DEPTH   = 512;
  localparam int GAP_DIVISOR  = 10;
  localparam int RANDOM_WORDS = 350;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic [1:0] {PH_TONE, PH_GAP, PH_PAUSE} play_phase_t;
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  msq_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  msq_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  melody_note_sequencer #(.NOTE_DEPTH(NOTE_DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Player state as the bench sees it
  bit [NOTE_W-1:0]    note_image [NOTE_DEPTH];
  bit [ADDR_IN_W-1:0] pl_start;
  bit [LEN_W-1:0]     pl_count;
  bit [LEN_W-1:0]     pl_pos;
  bit [DUR_W-1:0]     pl_dur;
  bit [DUR_W-1:0]     pl_gap;
  bit [FREQ_W-1:0]    pl_freq;
  bit [TICK_W-1:0]    pl_elapsed;
  play_phase_t        pl_phase = PH_TONE;
  bit                 pl_active;
  int unsigned        pl_loops;
  bit [TICK_W-1:0]    reg_pause = LOOP_PAUSE_RST;
  bit [LOOP_W-1:0]    reg_reps  = LOOP_REPS_RST;
  bit [DUR_W-1:0]     reg_floor = GAP_FLOOR_RST;

  msq_out_t    status_q [$];
  msq_out_t    want;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned cycle_count;
  int          burst_left;
  bit          sender_gaps = 1'b1;
  rx_mode_t    rx_mode = RX_RANDOM;
  int          rx_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void latch_note();
    bit [ADDR_IN_W-1:0] addr;
    bit [NOTE_W-1:0]    entry;
    int unsigned        g;
    addr     = pl_start + pl_pos[ADDR_IN_W-1:0];
    entry    = note_image[addr];
    pl_freq  = entry[NOTE_W-1:DUR_W];
    pl_dur   = entry[DUR_W-1:0];
    g        = 0;
    // rests carry no gap; a gap that would swallow the note is dropped
    if (pl_freq != '0) begin
      g = pl_dur / GAP_DIVISOR;
      if (g < reg_floor) g = reg_floor;
      if (g >= pl_dur) g = 0;
    end
    pl_gap     = g[DUR_W-1:0];
    pl_phase   = PH_TONE;
    pl_elapsed = '0;
  endfunction

  function automatic void advance_note();
    pl_pos = pl_pos + 1'b1;
    if (pl_pos >= pl_count) begin
      pl_phase   = PH_PAUSE;
      pl_elapsed = '0;
    end else begin
      latch_note();
    end
  endfunction

  function automatic bit tick_player();
    if (!pl_active) return 1'b0;
    if (pl_elapsed != '1) pl_elapsed++;
    case (pl_phase)
      PH_PAUSE: begin
        if (pl_elapsed >= reg_pause) begin
          pl_loops++;
          if (pl_loops >= reg_reps) begin
            pl_active = 1'b0;
            return 1'b1;
          end
          pl_pos = '0;
          latch_note();
        end
      end
      PH_GAP: begin
        if (pl_elapsed >= pl_gap) advance_note();
      end
      default: begin
        if (pl_elapsed >= pl_dur - pl_gap) begin
          if (pl_gap != '0) begin
            pl_phase   = PH_GAP;
            pl_elapsed = '0;
          end else begin
            advance_note();
          end
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic msq_out_t predict_status(msq_in_t w);
    msq_out_t r;
    bit       done;
    bit       sounding;
    done = 1'b0;
    case (w.action)
      ACT_TICK: done = tick_player();
      ACT_START: begin
        if (w.melody_length != '0) begin
          pl_start  = w.melody_start;
          pl_count  = w.melody_length;
          pl_pos    = '0;
          pl_loops  = 0;
          pl_active = 1'b1;
          latch_note();
        end
      end
      ACT_STOP: pl_active = 1'b0;
      ACT_WRITE: note_image[w.note_address] = {w.note_frequency, w.note_duration};
      default: ;
    endcase
    sounding         = pl_active && pl_phase == PH_TONE && pl_freq != '0;
    r.tone_on        = sounding;
    r.tone_frequency = sounding ? pl_freq : '0;
    r.playing        = pl_active;
    r.finished       = done;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic msq_in_t random_word(logic [1:0] act);
    logic [63:0] bits;
    msq_in_t     w;
    bits     = {$urandom, $urandom};
    w        = bits[$bits(msq_in_t)-1:0];
    w.action = act;
    return w;
  endfunction

  function automatic msq_in_t note_word(int unsigned addr, int unsigned freq,
                                        int unsigned dur);
    msq_in_t w;
    w                = random_word(ACT_WRITE);
    w.note_address   = addr[ADDR_IN_W-1:0];
    w.note_frequency = freq[FREQ_W-1:0];
    w.note_duration  = dur[DUR_W-1:0];
    return w;
  endfunction

  function automatic msq_in_t start_word(int unsigned first, int unsigned len);
    msq_in_t w;
    w               = random_word(ACT_START);
    w.melody_start  = first[ADDR_IN_W-1:0];
    w.melody_length = len[LEN_W-1:0];
    return w;
  endfunction

  function automatic int unsigned random_freq();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return 0;
    if (roll < 30) return 4095;
    return $urandom_range(1, 4095);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 0;
    if (roll < 70) return $urandom_range(1, 6);
    if (roll < 85) return $urandom_range(7, 64);
    if (roll < 96) return $urandom_range(65, NOTE_DEPTH - 1);
    return NOTE_DEPTH;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_word(msq_in_t w);
    int pause;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      pause = 0;
      if (sender_gaps && $urandom_range(0, 3) != 0) pause = $urandom_range(1, 8);
      if (pause > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(predict_status(w));
  endtask

  // Hold the input until every outstanding word has come back
  task automatic settle();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOOP_PAUSE: reg_pause = value[TICK_W-1:0];
      CFG_LOOP_REPS:  reg_reps  = value[LOOP_W-1:0];
      CFG_GAP_FLOOR:  reg_floor = value[DUR_W-1:0];
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(1, 12);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        flag_error($sformatf("unexpected result word %p", out_data));
      end else begin
        want = status_q.pop_front();
        if (out_data.tone_on !== want.tone_on)
          flag_error($sformatf("word %0d tone_on: expected %0b, got %0b",
                               results_seen, want.tone_on, out_data.tone_on));
        if (out_data.tone_frequency !== want.tone_frequency)
          flag_error($sformatf("word %0d tone_frequency: expected %0d, got %0d",
                               results_seen, want.tone_frequency,
                               out_data.tone_frequency));
        if (out_data.playing !== want.playing)
          flag_error($sformatf("word %0d playing: expected %0b, got %0b",
                               results_seen, want.playing, out_data.playing));
        if (out_data.finished !== want.finished)
          flag_error($sformatf("word %0d finished: expected %0b, got %0b",
                               results_seen, want.finished, out_data.finished));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** melody_note_sequencer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    write_reg(CFG_GAP_FLOOR, 1);
    write_reg(CFG_LOOP_PAUSE, 2);
    write_reg(CFG_LOOP_REPS, 2);
    // idle tick and idle stop leave the player silent
    send_word(random_word(ACT_TICK));
    send_word(random_word(ACT_STOP));
    send_word(note_word(NOTE_DEPTH - 1, 440, 3));
    send_word(note_word(0, 0, 0));
    send_word(note_word(1, 4095, 4095));
    send_word(note_word(2, 1, 0));
    send_word(start_word(5, 0));
    // wrap from the top of the store into address 0
    send_word(start_word(NOTE_DEPTH - 1, 3));
    repeat (4) send_word(random_word(ACT_TICK));
    // overwrite the sounding note; the latched values must hold
    send_word(note_word(1, 300, 2));
    send_word(random_word(ACT_TICK));
    // restart mid-note, then two plays of a one-tick note ending in finished
    send_word(start_word(2, 1));
    repeat (6) send_word(random_word(ACT_TICK));
    send_word(start_word(NOTE_DEPTH - 1, 3));
    send_word(random_word(ACT_STOP));
    send_word(random_word(ACT_TICK));
  endtask

  task automatic test_full_memory();
    settle();
    write_reg(CFG_LOOP_PAUSE, 3);
    write_reg(CFG_LOOP_REPS, 1);
    write_reg(CFG_GAP_FLOOR, 0);
    rx_mode = RX_RANDOM;
    for (int a = 0; a < NOTE_DEPTH; a++)
      send_word(note_word(a, random_freq(),
                          $urandom_range(0, 4) == 0 ? $urandom_range(1, 15) : 0));
    send_word(start_word($urandom_range(0, NOTE_DEPTH - 1), NOTE_DEPTH));
    // play the head of the longest melody, then cut it short
    repeat (80) send_word(random_word(ACT_TICK));
    send_word(random_word(ACT_STOP));
  endtask

  task automatic test_many_loops();
    settle();
    write_reg(CFG_LOOP_PAUSE, 0);
    write_reg(CFG_LOOP_REPS, 8);
    write_reg(CFG_GAP_FLOOR, 0);
    rx_mode     = RX_ALWAYS;
    sender_gaps = 1'b0;
    send_word(note_word(100, 0, 0));
    send_word(start_word(100, 1));
    while (pl_active) send_word(random_word(ACT_TICK));
    // a repeat count of zero plays once
    settle();
    write_reg(CFG_LOOP_REPS, 0);
    send_word(start_word(100, 1));
    while (pl_active) send_word(random_word(ACT_TICK));
    sender_gaps = 1'b1;
  endtask

  task automatic test_long_pause();
    settle();
    write_reg(CFG_LOOP_PAUSE, 65535);
    write_reg(CFG_LOOP_REPS, 1);
    write_reg(CFG_GAP_FLOOR, 4095);
    rx_mode     = RX_ALWAYS;
    sender_gaps = 1'b0;
    send_word(note_word(7, 123, 2));
    send_word(start_word(7, 1));
    // run into the pause, then cut it short
    repeat (30) send_word(random_word(ACT_TICK));
    send_word(random_word(ACT_STOP));
    send_word(random_word(ACT_TICK));
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_play();
    int unsigned words_random;
    int unsigned roll;
    int unsigned phase_words;
    int unsigned dur;
    bit          ignored;
    msq_in_t     w;
    words_random = 0;
    while (words_random < RANDOM_WORDS) begin
      settle();
      roll = $urandom_range(0, 99);
      write_reg(CFG_LOOP_PAUSE, roll < 25 ? 0 : roll < 65 ? $urandom_range(1, 8) :
                                roll < 95 ? $urandom_range(9, 40) : 65535);
      roll = $urandom_range(0, 99);
      write_reg(CFG_LOOP_REPS, roll < 10 ? 0 : roll < 50 ? 1 :
                               roll < 90 ? $urandom_range(2, 4) : 255);
      roll = $urandom_range(0, 99);
      write_reg(CFG_GAP_FLOOR, roll < 25 ? 0 : roll < 60 ? $urandom_range(1, 5) :
                               roll < 75 ? 20 : roll < 90 ? 4095 : $urandom_range(0, 4095));
      rx_mode     = rx_mode_t'($urandom_range(0, 2));
      sender_gaps = ($urandom_range(0, 3) != 0);
      phase_words = $urandom_range(30, 120);
      repeat (phase_words) begin
        if ($urandom_range(0, 59) == 0) settle();
        roll = $urandom_range(0, 99);
        dur  = $urandom_range(0, 9) < 6 ? $urandom_range(0, 12) :
               $urandom_range(0, 2) != 0 ? $urandom_range(13, 60) : $urandom_range(0, 4095);
        if (pl_active) begin
          if (roll < 80)      w = random_word(ACT_TICK);
          else if (roll < 87) w = note_word($urandom_range(0, NOTE_DEPTH - 1), random_freq(), dur);
          else if (roll < 91) w = random_word(ACT_STOP);
          else if (roll < 96) w = start_word($urandom_range(0, NOTE_DEPTH - 1), pick_length());
          else                w = random_word(2'($urandom_range(0, 3)));
        end else begin
          if (roll < 55)      w = start_word($urandom_range(0, NOTE_DEPTH - 1), pick_length());
          else if (roll < 65) w = random_word(ACT_TICK);
          else if (roll < 70) w = random_word(ACT_STOP);
          else if (roll < 85) w = note_word($urandom_range(0, NOTE_DEPTH - 1), random_freq(), dur);
          else                w = random_word(2'($urandom_range(0, 3)));
        end
        // keep noisy starts within the melody length range
        if (w.action == ACT_START && w.melody_length > NOTE_DEPTH)
          w.melody_length = LEN_W'($urandom_range(0, NOTE_DEPTH));
        ignored = (w.action == ACT_START) ? (w.melody_length == '0) :
                  (w.action != ACT_WRITE && !pl_active);
        if (!ignored) words_random++;
        send_word(w);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_memory();
    test_many_loops();
    test_long_pause();
    test_random_play();
    settle();
    if (fail_count == 0) begin
      $display("** melody_note_sequencer: PASSED **");
    end else begin
      $display("** melody_note_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/msq_pkg.sv
sv/msq_note_mem.sv
sv/msq_out_queue.sv
sv/melody_note_sequencer.sv
test/testbench.sv
